FILE: rtl/core/irpd_pkg.sv
// Package for the IR pulse-distance receiver.
// Holds frame geometry, interval classes, register indexes and shared types.
// No dependencies.
package irpd_pkg;

	localparam int FRAME_BITS = 16;
	localparam int CNT_W      = $clog2(FRAME_BITS);
	localparam int WORD_W     = 16;
	localparam int TIME_W     = 32;
	localparam int THR_W      = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ZERO  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ONE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_START = 2'd3;

	localparam logic [THR_W-1:0] RST_MIN_VALID = 16'd316;
	localparam logic [THR_W-1:0] RST_MAX_ZERO  = 16'd526;
	localparam logic [THR_W-1:0] RST_MAX_ONE   = 16'd947;
	localparam logic [THR_W-1:0] RST_MAX_START = 16'd1597;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [THR_W-1:0]  thr_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		CLS_ERR,
		CLS_ZERO,
		CLS_ONE,
		CLS_START
	} class_t;

	typedef struct packed {
		thr_t min_valid;
		thr_t max_zero;
		thr_t max_one;
		thr_t max_start;
	} thresholds_t;

	typedef struct packed {
		logic   valid;
		class_t cls;
	} step_t;

endpackage

FILE: rtl/core/irpd_edge_if.sv
// Edge event channel: valid/ready handshake with level and timestamp.
// Depends on irpd_pkg.
interface irpd_edge_if;
	logic             valid;
	logic             ready;
	logic             edge_level;
	irpd_pkg::time_t  time_us;

	modport source (output valid, output edge_level, output time_us, input ready);
	modport sink (input valid, input edge_level, input time_us, output ready);
endinterface

FILE: rtl/core/irpd_frame_if.sv
// Frame word channel: valid/ready handshake with the collected frame bits.
// Depends on irpd_pkg.
interface irpd_frame_if;
	logic             valid;
	logic             ready;
	irpd_pkg::word_t  frame_bits;

	modport source (output valid, output frame_bits, input ready);
	modport sink (input valid, input frame_bits, output ready);
endinterface

FILE: rtl/core/irpd_interval.sv
// Interval measurement: holds the last rising edge time and classifies
// the interval to the current rising edge. Depends on irpd_pkg.
module irpd_interval (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rise,
	input  irpd_pkg::time_t        time_us,
	input  irpd_pkg::thresholds_t  thr,
	output irpd_pkg::step_t        step
);
	import irpd_pkg::*;

	time_t  prev_rise_q;
	time_t  interval;
	class_t cls;

	assign interval = time_us - prev_rise_q;

	always_comb begin
		priority if (interval < TIME_W'(thr.min_valid)) begin
			cls = CLS_ERR;
		end else if (interval <= TIME_W'(thr.max_zero)) begin
			cls = CLS_ZERO;
		end else if (interval <= TIME_W'(thr.max_one)) begin
			cls = CLS_ONE;
		end else if (interval <= TIME_W'(thr.max_start)) begin
			cls = CLS_START;
		end else begin
			cls = CLS_ERR;
		end
	end

	assign step.valid = rise;
	assign step.cls   = cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_rise_q <= '0;
		end else if (rise) begin
			prev_rise_q <= time_us;
		end
	end

endmodule

FILE: rtl/core/irpd_assembler.sv
// Frame assembly: bit slots, slot counter and the frame output register.
// Depends on irpd_pkg and irpd_frame_if.
module irpd_assembler (
	input  logic               clk,
	input  logic               arst_n,
	input  irpd_pkg::step_t    step,
	output logic               take,
	irpd_frame_if.source       frame_out
);
	import irpd_pkg::*;

	logic [FRAME_BITS-1:0] slots_q;
	logic [FRAME_BITS-1:0] slots_d;
	logic [CNT_W-1:0]      slot_cnt_q;
	logic [CNT_W:0]        cnt_next;
	logic                  restart;
	logic                  emit;
	logic                  out_valid_q;
	word_t                 frame_q;
	word_t                 frame_d;
	logic                  upd;

	assign take    = !out_valid_q || frame_out.ready;
	assign upd     = step.valid && take;
	assign restart = (step.cls == CLS_START) || (step.cls == CLS_ERR);

	always_comb begin
		slots_d             = slots_q;
		slots_d[slot_cnt_q] = (step.cls == CLS_ONE);
	end

	assign cnt_next = restart ? (CNT_W+1)'(1) : ({1'b0, slot_cnt_q} + (CNT_W+1)'(1));
	assign emit     = (cnt_next == (CNT_W+1)'(FRAME_BITS));

	for (genvar i = 0; i < WORD_W; i++) begin : g_word
		if (i < FRAME_BITS) begin : g_bit
			assign frame_d[i] = slots_d[i];
		end else begin : g_pad
			assign frame_d[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q     <= '0;
			slot_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd) begin
				slots_q    <= slots_d;
				slot_cnt_q <= emit ? '0 : cnt_next[CNT_W-1:0];
			end
			if (take) begin
				out_valid_q <= upd && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd && emit) begin
			frame_q <= frame_d;
		end
	end

	assign frame_out.valid      = out_valid_q;
	assign frame_out.frame_bits = frame_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, slot_cnt_q} < (CNT_W+1)'(FRAME_BITS))
		else $error("slot counter out of range");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && emit) |=> (slot_cnt_q == '0) && out_valid_q)
		else $error("frame emitted without clearing the counter");

	a_restart_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && restart && !emit) |=> (slot_cnt_q == CNT_W'(1)))
		else $error("start or error did not restart the counter");

	a_one_stored: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && step.cls == CLS_ONE) |=> slots_q[$past(slot_cnt_q)])
		else $error("one bit not stored");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(!take) |=> $stable(slot_cnt_q) && $stable(slots_q))
		else $error("state changed while output stalled");

endmodule

FILE: rtl/core/ir_pulse_distance_receiver_top.sv
// Top level of the IR pulse-distance receiver: input register, threshold
// registers and the interval and assembly stages. Depends on irpd_pkg,
// irpd_edge_if, irpd_frame_if, irpd_interval and irpd_assembler.
//
//   channel    dir  payload                      transaction when
//   edge_in    in   edge_level, time_us[31:0]    valid && ready
//   frame_out  out  frame_bits[15:0]             valid && ready
//   cfg        in   cfg_index[1:0], cfg_data     cfg_we
//
// An edge is registered on acceptance and processed once take is high;
// the frame word is registered as its completing rising edge is processed.
// One edge per cycle is sustained while frame_out is not stalled.
// A stalled frame word holds the processing stage; the input register still
// takes one more edge. Reset clears the counter, slots, last rise time and
// loads the default thresholds.
module ir_pulse_distance_receiver_top (
	input  logic                             clk,
	input  logic                             arst_n,
	irpd_edge_if.sink                        edge_in,
	irpd_frame_if.source                     frame_out,
	input  logic                             cfg_we,
	input  logic [irpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  irpd_pkg::thr_t                   cfg_data
);
	import irpd_pkg::*;

	thresholds_t thr_q;
	logic        valid_s1;
	logic        level_s1;
	time_t       time_s1;
	logic        take;
	logic        rise;
	step_t       step;
	logic        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.min_valid <= RST_MIN_VALID;
			thr_q.max_zero  <= RST_MAX_ZERO;
			thr_q.max_one   <= RST_MAX_ONE;
			thr_q.max_start <= RST_MAX_START;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_VALID: thr_q.min_valid <= cfg_data;
				REG_MAX_ZERO:  thr_q.max_zero  <= cfg_data;
				REG_MAX_ONE:   thr_q.max_one   <= cfg_data;
				REG_MAX_START: thr_q.max_start <= cfg_data;
			endcase
		end
	end

	assign edge_in.ready = !valid_s1 || take;
	assign accept        = edge_in.valid && edge_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1 <= edge_in.edge_level;
			time_s1  <= edge_in.time_us;
		end
	end

	assign rise = valid_s1 && level_s1 && take;

	irpd_interval u_interval (
		.clk     (clk),
		.arst_n  (arst_n),
		.rise    (rise),
		.time_us (time_s1),
		.thr     (thr_q),
		.step    (step)
	);

	irpd_assembler u_assembler (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.take      (take),
		.frame_out (frame_out)
	);

endmodule
